>>> rtl/tpa_pkg.sv
// Shared types and fixed widths for the triangle perimeter and area block.
`timescale 1ns / 1ps
package tpa_pkg;

    // Input coordinates and fixed point format
    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 8;
    localparam int NUM_SIDES = 3;

    // Side length datapath
    localparam int DIFF_W  = COORD_W;
    localparam int SUMSQ_W = 2 * DIFF_W + 1;
    localparam int SRAD_W  = ((SUMSQ_W + 2 * FRAC_BITS + 1) / 2) * 2;
    localparam int SIDE_W  = SRAD_W / 2;
    localparam int PSUM_W  = SIDE_W + 2;

    // Heron datapath
    localparam int HALF_W  = PSUM_W;
    localparam int F_W     = 2 * PSUM_W;
    localparam int PROD_W  = 2 * F_W;
    localparam int SHIFT   = 4 + 2 * FRAC_BITS;
    localparam int ARAD_W  = PROD_W - SHIFT;
    localparam int AROOT_W = ARAD_W / 2;

    // Result fields
    localparam int PERIM_W = 26;
    localparam int AREA_W  = 39;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } vertex_t;

    typedef struct packed {
        logic [PERIM_W-1:0] perimeter;
        logic [AREA_W-1:0]  area;
    } result_t;

    // One queued item: the three sides and their sum
    typedef struct packed {
        logic [SIDE_W-1:0] sa;
        logic [SIDE_W-1:0] sb;
        logic [SIDE_W-1:0] sc;
        logic [PSUM_W-1:0] p;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> rtl/tpa_isqrt.sv
// Pipelined integer square root, one result bit per stage, several lanes.
`timescale 1ns / 1ps
module tpa_isqrt #(
    parameter int IN_W   = 50,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1,
    localparam int OUT_W = IN_W / 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [IN_W-1:0]   radicand [LANES],
    input  logic [SIDE_W-1:0] side,
    output logic [OUT_W-1:0]  root [LANES],
    output logic [SIDE_W-1:0] side_out
);

    localparam int REM_W = OUT_W + 2;

    logic [REM_W-1:0]  rem_reg  [OUT_W][LANES];
    logic [OUT_W-1:0]  root_reg [OUT_W][LANES];
    logic [IN_W-1:0]   rad_reg  [OUT_W][LANES];
    logic [SIDE_W-1:0] side_reg [OUT_W];

    genvar s;
    for (s = 0; s < OUT_W; s++)
    begin : g_stage
        logic [REM_W-1:0]  rem_in    [LANES];
        logic [OUT_W-1:0]  root_in   [LANES];
        logic [IN_W-1:0]   rad_in    [LANES];
        logic [SIDE_W-1:0] side_in;
        logic [REM_W-1:0]  cur       [LANES];
        logic [REM_W-1:0]  trial     [LANES];
        logic [REM_W-1:0]  rem_next  [LANES];
        logic [OUT_W-1:0]  root_next [LANES];
        logic [IN_W-1:0]   rad_next  [LANES];

        // stage input: from the ports or the previous stage
        if (s == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l]  = '0;
                    root_in[l] = '0;
                    rad_in[l]  = radicand[l];
                end
                side_in = side;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l]  = rem_reg[s-1][l];
                    root_in[l] = root_reg[s-1][l];
                    rad_in[l]  = rad_reg[s-1][l];
                end
                side_in = side_reg[s-1];
            end
        end

        // bring down two radicand bits, try the next root bit
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                cur[l]   = {rem_in[l][REM_W-3:0], rad_in[l][IN_W-1 -: 2]};
                trial[l] = {root_in[l], 2'b01};
                if (cur[l] >= trial[l])
                begin
                    rem_next[l]  = cur[l] - trial[l];
                    root_next[l] = {root_in[l][OUT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l]  = cur[l];
                    root_next[l] = {root_in[l][OUT_W-2:0], 1'b0};
                end
                rad_next[l] = rad_in[l] << 2;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l]  <= '0;
                    root_reg[s][l] <= '0;
                    rad_reg[s][l]  <= '0;
                end
                side_reg[s] <= '0;
            end
            else if (en)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l]  <= rem_next[l];
                    root_reg[s][l] <= root_next[l];
                    rad_reg[s][l]  <= rad_next[l];
                end
                side_reg[s] <= side_in;
            end
        end
    end

    // last stage holds the finished roots
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            root[l] = root_reg[OUT_W-1][l];
        end
        side_out = side_reg[OUT_W-1];
    end

endmodule

>>> rtl/tpa_front.sv
// Front end: takes vertex items, works out the three sides and the perimeter.
`timescale 1ns / 1ps
module tpa_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   vertex_valid,
    output logic                   vertex_stall,
    input  tpa_pkg::vertex_t       vertex,
    input  tpa_pkg::queue_status_t qst,
    output logic                   push,
    output tpa_pkg::queue_entry_t  entry
);

    import tpa_pkg::*;

    // |a - b| of two coordinates
    function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                   logic signed [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[DIFF_W-1:0];
    endfunction

    logic                en_f;
    logic                s1_valid_reg;
    logic [DIFF_W-1:0]   dx_reg    [NUM_SIDES];
    logic [DIFF_W-1:0]   dy_reg    [NUM_SIDES];
    logic                s2_valid_reg;
    logic [SUMSQ_W-1:0]  sumsq_reg [NUM_SIDES];
    logic [SUMSQ_W-1:0]  sumsq_next[NUM_SIDES];
    logic [SRAD_W-1:0]   radicand  [NUM_SIDES];
    logic [SIDE_W-1:0]   sides     [NUM_SIDES];
    logic                sq_valid;
    logic                p_valid_reg;
    queue_entry_t        entry_reg;

    // whole pipeline holds while the finished item cannot enter the queue
    assign en_f         = !p_valid_reg || !qst.full;
    assign vertex_stall = !en_f;
    assign push         = p_valid_reg && !qst.full;
    assign entry        = entry_reg;

    // stage 1: absolute coordinate differences for each side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en_f)
        begin
            s1_valid_reg <= vertex_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            dx_reg[0] <= abs_diff(vertex.cx, vertex.bx);
            dy_reg[0] <= abs_diff(vertex.cy, vertex.by);
            dx_reg[1] <= abs_diff(vertex.cx, vertex.ax);
            dy_reg[1] <= abs_diff(vertex.cy, vertex.ay);
            dx_reg[2] <= abs_diff(vertex.bx, vertex.ax);
            dy_reg[2] <= abs_diff(vertex.by, vertex.ay);
        end
    end

    // stage 2: squared lengths
    always_comb
    begin
        for (int l = 0; l < NUM_SIDES; l++)
        begin
            sumsq_next[l] = SUMSQ_W'({{DIFF_W{1'b0}}, dx_reg[l]} * {{DIFF_W{1'b0}}, dx_reg[l]})
                          + SUMSQ_W'({{DIFF_W{1'b0}}, dy_reg[l]} * {{DIFF_W{1'b0}}, dy_reg[l]});
            radicand[l]   = SRAD_W'({sumsq_reg[l], {(2 * FRAC_BITS){1'b0}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en_f)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            for (int l = 0; l < NUM_SIDES; l++)
            begin
                sumsq_reg[l] <= sumsq_next[l];
            end
        end
    end

    // side lengths, three lanes in step
    tpa_isqrt #(
        .IN_W   (SRAD_W),
        .LANES  (NUM_SIDES),
        .SIDE_W (1)
    ) u_side_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_f),
        .radicand (radicand),
        .side     (s2_valid_reg),
        .root     (sides),
        .side_out (sq_valid)
    );

    // last stage: sides and perimeter, held for the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en_f)
        begin
            p_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            entry_reg.sa <= sides[0];
            entry_reg.sb <= sides[1];
            entry_reg.sc <= sides[2];
            entry_reg.p  <= PSUM_W'(sides[0]) + PSUM_W'(sides[1]) + PSUM_W'(sides[2]);
        end
    end

endmodule

>>> rtl/tpa_queue.sv
// Short queue between front and back end.
`timescale 1ns / 1ps
module tpa_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tpa_pkg::queue_entry_t  entry,
    input  logic                   pop,
    output tpa_pkg::queue_entry_t  head,
    output tpa_pkg::queue_status_t qst
);

    import tpa_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign head      = mem_reg[rd_ptr_reg];
    assign qst.full  = (count_reg == CNT_W'(DEPTH));
    assign qst.empty = (count_reg == '0);

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

>>> rtl/tpa_back.sv
// Back end: Heron product, area root, saturation and the result register.
`timescale 1ns / 1ps
module tpa_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tpa_pkg::queue_status_t qst,
    input  tpa_pkg::queue_entry_t  head,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output tpa_pkg::result_t       result
);

    import tpa_pkg::*;

    localparam int SQ_SIDE_W = PSUM_W + 2;

    logic                en_b;
    logic [PSUM_W:0]     d0;
    logic [PSUM_W:0]     d1;
    logic [PSUM_W:0]     d2;

    // B1: factors P-2a, P-2b, P-2c
    logic                b1_valid_reg;
    logic                b1_ok_reg;
    logic [PSUM_W-1:0]   b1_p_reg;
    logic [PSUM_W-1:0]   b1_d0_reg;
    logic [PSUM_W-1:0]   b1_d1_reg;
    logic [PSUM_W-1:0]   b1_d2_reg;
    // B2: the two half products
    logic                b2_valid_reg;
    logic                b2_ok_reg;
    logic [PSUM_W-1:0]   b2_p_reg;
    logic [F_W-1:0]      f1_reg;
    logic [F_W-1:0]      f2_reg;
    // B3: partial products
    logic                b3_valid_reg;
    logic                b3_ok_reg;
    logic [PSUM_W-1:0]   b3_p_reg;
    logic [F_W-1:0]      pp00_reg;
    logic [F_W-1:0]      pp01_reg;
    logic [F_W-1:0]      pp10_reg;
    logic [F_W-1:0]      pp11_reg;
    // B4: middle terms summed
    logic                b4_valid_reg;
    logic                b4_ok_reg;
    logic [PSUM_W-1:0]   b4_p_reg;
    logic [F_W-1:0]      lo_reg;
    logic [F_W-1:0]      hi_reg;
    logic [F_W:0]        mid_reg;
    // B5: full product
    logic                b5_valid_reg;
    logic                b5_ok_reg;
    logic [PSUM_W-1:0]   b5_p_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic [ARAD_W-1:0]    arad     [1];
    logic [AROOT_W-1:0]   aroot    [1];
    logic [SQ_SIDE_W-1:0] sq_side_in;
    logic [SQ_SIDE_W-1:0] sq_side_out;
    logic                 sq_valid;
    logic                 sq_ok;
    logic [PSUM_W-1:0]    sq_p;
    result_t              result_next;
    logic                 out_valid_reg;
    result_t              result_reg;

    // the back end holds only while a finished result waits
    assign en_b         = !out_valid_reg || !result_stall;
    assign pop          = en_b && !qst.empty;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    assign d0 = {1'b0, head.p} - (PSUM_W + 1)'({head.sa, 1'b0});
    assign d1 = {1'b0, head.p} - (PSUM_W + 1)'({head.sb, 1'b0});
    assign d2 = {1'b0, head.p} - (PSUM_W + 1)'({head.sc, 1'b0});

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
        end
        else if (en_b)
        begin
            b1_valid_reg <= !qst.empty;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
        end
    end

    // arithmetic stages
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            // a factor below zero means no area
            b1_ok_reg <= !d0[PSUM_W] && !d1[PSUM_W] && !d2[PSUM_W];
            b1_p_reg  <= head.p;
            b1_d0_reg <= d0[PSUM_W-1:0];
            b1_d1_reg <= d1[PSUM_W-1:0];
            b1_d2_reg <= d2[PSUM_W-1:0];

            b2_ok_reg <= b1_ok_reg;
            b2_p_reg  <= b1_p_reg;
            f1_reg    <= F_W'(b1_p_reg) * F_W'(b1_d0_reg);
            f2_reg    <= F_W'(b1_d1_reg) * F_W'(b1_d2_reg);

            b3_ok_reg <= b2_ok_reg;
            b3_p_reg  <= b2_p_reg;
            pp00_reg  <= F_W'(f1_reg[HALF_W-1:0]) * F_W'(f2_reg[HALF_W-1:0]);
            pp01_reg  <= F_W'(f1_reg[HALF_W-1:0]) * F_W'(f2_reg[F_W-1:HALF_W]);
            pp10_reg  <= F_W'(f1_reg[F_W-1:HALF_W]) * F_W'(f2_reg[HALF_W-1:0]);
            pp11_reg  <= F_W'(f1_reg[F_W-1:HALF_W]) * F_W'(f2_reg[F_W-1:HALF_W]);

            b4_ok_reg <= b3_ok_reg;
            b4_p_reg  <= b3_p_reg;
            lo_reg    <= pp00_reg;
            hi_reg    <= pp11_reg;
            mid_reg   <= (F_W + 1)'(pp01_reg) + (F_W + 1)'(pp10_reg);

            b5_ok_reg <= b4_ok_reg;
            b5_p_reg  <= b4_p_reg;
            prod_reg  <= {hi_reg, lo_reg} + (PROD_W'(mid_reg) << HALF_W);
        end
    end

    // area root over the scaled product
    assign arad[0]    = prod_reg[PROD_W-1:SHIFT];
    assign sq_side_in = {b5_valid_reg, b5_ok_reg, b5_p_reg};

    tpa_isqrt #(
        .IN_W   (ARAD_W),
        .LANES  (1),
        .SIDE_W (SQ_SIDE_W)
    ) u_area_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_b),
        .radicand (arad),
        .side     (sq_side_in),
        .root     (aroot),
        .side_out (sq_side_out)
    );

    assign sq_valid = sq_side_out[SQ_SIDE_W-1];
    assign sq_ok    = sq_side_out[SQ_SIDE_W-2];
    assign sq_p     = sq_side_out[PSUM_W-1:0];

    // saturate both fields to their widths
    always_comb
    begin
        if (|sq_p[PSUM_W-1:PERIM_W])
        begin
            result_next.perimeter = '1;
        end
        else
        begin
            result_next.perimeter = sq_p[PERIM_W-1:0];
        end
        if (!sq_ok)
        begin
            result_next.area = '0;
        end
        else if (|aroot[0][AROOT_W-1:AREA_W])
        begin
            result_next.area = '1;
        end
        else
        begin
            result_next.area = aroot[0][AREA_W-1:0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_b)
        begin
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            result_reg <= result_next;
        end
    end

endmodule

>>> rtl/triangle_perimeter_area.sv
// Top level of the triangle perimeter and area block.
`timescale 1ns / 1ps
// Triangle perimeter and area (Heron) in unsigned fixed point, 8 fraction bits.
// Input channel: vertex_valid / vertex_stall with vertex = {ax, ay, bx, by, cx, cy},
// signed 16-bit coordinates. An item is taken on a clock edge with valid high and
// stall low. Output channel: result_valid / result_stall with result =
// {perimeter, area}; perimeter and area saturate at their field maximum, and the
// area is zero when a Heron factor comes out negative.
// Throughput: one item per cycle while nothing stalls. In the front end the
// differences, squares, side root (one bit a stage) and sides with perimeter are
// registered; then the queue, B1 to B5, the area root and the result register.
// The front end and back end stall separately with a short queue between them.
// The back end freezes only while the result register holds an item that is
// stalled; the front end freezes only when its last item finds the queue full,
// which then shows as vertex_stall.
// Reset clears all valid flags and the queue; the block is ready at once.
module triangle_perimeter_area #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  tpa_pkg::vertex_t  vertex,
    output logic              result_valid,
    input  logic              result_stall,
    output tpa_pkg::result_t  result
);

    import tpa_pkg::*;

    queue_status_t qst;
    queue_entry_t  entry;
    queue_entry_t  head;
    logic          push;
    logic          pop;

    tpa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .qst          (qst),
        .push         (push),
        .entry        (entry)
    );

    tpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .entry (entry),
        .pop   (pop),
        .head  (head),
        .qst   (qst)
    );

    tpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qst          (qst),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // queue never written when full nor read when empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qst.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qst.empty)
        else $error("queue read while empty");

    // a push into an empty queue leaves it non-empty next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && qst.empty) |=> !qst.empty)
        else $error("pushed item lost");

endmodule
